### rtl/core/dns_question_parser_macros.svh
// Assertion macros shared by the DNS question parser RTL.
`ifndef DNS_QUESTION_PARSER_MACROS_SVH
`define DNS_QUESTION_PARSER_MACROS_SVH

// Check that the consequent holds in the same cycle as the antecedent.
`define DQP_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Check that the consequent holds in the cycle after the antecedent.
`define DQP_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/core/dqp_pkg.sv
// Types and constants for the DNS question parser.
`timescale 1ns / 1ps
package dqp_pkg;

  localparam int HEADER_BYTES     = 12;
  localparam int HDR_FLAGS_OFFSET = 2;
  localparam int MAX_LABEL_LEN    = 63;
  localparam int MAX_NAME_END     = 255;
  localparam int LABEL_W          = $clog2(MAX_LABEL_LEN + 1);

  localparam logic [15:0] OPT_TYPE  = 16'd41;
  localparam logic [15:0] UDP_FLOOR = 16'd512;

  localparam int RES_DEPTH  = 4;
  localparam int RES_PTR_W  = $clog2(RES_DEPTH);
  localparam int RES_FILL_W = $clog2(RES_DEPTH + 1);

  localparam logic [2:0] ST_OK           = 3'd0;
  localparam logic [2:0] ST_UNTERMINATED = 3'd1;
  localparam logic [2:0] ST_LABEL_LONG   = 3'd2;
  localparam logic [2:0] ST_LABEL_BEYOND = 3'd3;
  localparam logic [2:0] ST_MALFORMED    = 3'd4;
  localparam logic [2:0] ST_NAME_LONG    = 3'd5;
  localparam logic [2:0] ST_TRUNCATED    = 3'd6;

  localparam logic KIND_NAME    = 1'b0;
  localparam logic KIND_SUMMARY = 1'b1;

  typedef struct packed {
    logic        item_kind;
    logic [7:0]  name_byte;
    logic [2:0]  status;
    logic [15:0] query_type;
    logic [15:0] query_class;
    logic [6:0]  label_total;
    logic [7:0]  name_wire_length;
    logic        recursion_wanted;
    logic [7:0]  edns_version;
    logic [15:0] edns_udp_size;
    logic        edns_do;
  } result_t;

  typedef struct packed {
    logic [1:0] count;
  } push_t;

  function automatic logic [7:0] to_lower(input logic [7:0] b);
    logic upper;
    upper = (b >= 8'h41) && (b <= 8'h5a);
    return upper ? (b | 8'h20) : b;
  endfunction

endpackage

### rtl/core/dqp_in_if.sv
// Packet byte channel into the DNS question parser.
`timescale 1ns / 1ps
interface dqp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       last_byte;
  logic       has_additional;

  modport source(output valid, output data_byte, output last_byte, output has_additional,
                 input ready);
  modport sink(input valid, input data_byte, input last_byte, input has_additional,
               output ready);
endinterface

### rtl/core/dqp_out_if.sv
// Result channel out of the DNS question parser.
`timescale 1ns / 1ps
interface dqp_out_if;
  logic        valid;
  logic        ready;
  logic        item_kind;
  logic [7:0]  name_byte;
  logic [2:0]  status;
  logic [15:0] query_type;
  logic [15:0] query_class;
  logic [6:0]  label_total;
  logic [7:0]  name_wire_length;
  logic        recursion_wanted;
  logic [7:0]  edns_version;
  logic [15:0] edns_udp_size;
  logic        edns_do;

  modport source(output valid, output item_kind, output name_byte, output status,
                 output query_type, output query_class, output label_total,
                 output name_wire_length, output recursion_wanted, output edns_version,
                 output edns_udp_size, output edns_do, input ready);
  modport sink(input valid, input item_kind, input name_byte, input status,
               input query_type, input query_class, input label_total,
               input name_wire_length, input recursion_wanted, input edns_version,
               input edns_udp_size, input edns_do, output ready);
endinterface

### rtl/core/dqp_parse.sv
// Per-byte parse state and result generation for the DNS question parser.
`timescale 1ns / 1ps
module dqp_parse #(
  parameter int OFFSET_BITS = 16
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             fire,
  input  logic [7:0]       data_byte,
  input  logic             last_byte,
  input  logic             has_additional,
  output dqp_pkg::push_t   push,
  output dqp_pkg::result_t item_a,
  output dqp_pkg::result_t item_b
);
  import dqp_pkg::*;

  typedef enum logic [1:0] {PH_HEADER, PH_NAME, PH_TRAILER} phase_t;

  localparam int REL_QTYPE_HI  = 1;
  localparam int REL_QTYPE_LO  = 2;
  localparam int REL_QCLASS_HI = 3;
  localparam int REL_QCLASS_LO = 4;
  localparam int REL_OWNER     = 5;
  localparam int REL_OTYPE_HI  = 6;
  localparam int REL_OTYPE_LO  = 7;
  localparam int REL_OCLASS_HI = 8;
  localparam int REL_OCLASS_LO = 9;
  localparam int REL_VERSION   = 11;
  localparam int REL_DO        = 12;
  localparam int MIN_TRAILER   = 4;
  localparam int MIN_OPT       = 15;

  localparam logic [OFFSET_BITS-1:0] OFF_MAX = {OFFSET_BITS{1'b1}};

  phase_t                 phase, phase_next;
  logic [OFFSET_BITS-1:0] byte_offset, byte_offset_next;
  logic [LABEL_W-1:0]     label_left, label_left_next;
  logic [2:0]             first_error, first_error_next;
  logic                   terminator_seen, terminator_seen_next;
  logic [OFFSET_BITS-1:0] name_end_offset, name_end_offset_next;
  logic [6:0]             label_tally, label_tally_next;
  logic [15:0]            qtype, qtype_next;
  logic [15:0]            qclass, qclass_next;
  logic                   rd, rd_next;
  logic [15:0]            opt_type, opt_type_next;
  logic [15:0]            opt_class, opt_class_next;
  logic [7:0]             opt_version, opt_version_next;
  logic                   opt_do, opt_do_next;
  logic                   opt_owner_nz, opt_owner_nz_next;
  logic                   additional_flag, additional_flag_next;

  logic [OFFSET_BITS-1:0] rel;
  logic [OFFSET_BITS:0]   off_ext, end_p4, end_p15;
  logic [2:0]             label_code;
  logic                   opt_ok;
  result_t                name_item, summary;

  always_comb begin
    phase_next           = phase;
    byte_offset_next     = byte_offset;
    label_left_next      = label_left;
    first_error_next     = first_error;
    terminator_seen_next = terminator_seen;
    name_end_offset_next = name_end_offset;
    label_tally_next     = label_tally;
    qtype_next           = qtype;
    qclass_next          = qclass;
    rd_next              = rd;
    opt_type_next        = opt_type;
    opt_class_next       = opt_class;
    opt_version_next     = opt_version;
    opt_do_next          = opt_do;
    opt_owner_nz_next    = opt_owner_nz;
    additional_flag_next = additional_flag;
    label_code           = ST_OK;
    rel                  = byte_offset - name_end_offset;

    if (fire) begin
      if (byte_offset != OFF_MAX) begin
        byte_offset_next = byte_offset + 1'b1;
      end
      case (phase)
        PH_HEADER: begin
          if (byte_offset == '0) begin
            additional_flag_next = has_additional;
          end
          if (byte_offset == OFFSET_BITS'(HDR_FLAGS_OFFSET)) begin
            rd_next = data_byte[0];
          end
          if (byte_offset >= OFFSET_BITS'(HEADER_BYTES - 1)) begin
            phase_next = PH_NAME;
          end
        end
        PH_NAME: begin
          if (data_byte == 8'h00) begin
            if (label_left > LABEL_W'(1)) begin
              label_code = ST_LABEL_BEYOND;
            end else if (label_left == LABEL_W'(1)) begin
              label_code = ST_MALFORMED;
            end
            label_left_next      = '0;
            terminator_seen_next = 1'b1;
            name_end_offset_next = byte_offset;
            phase_next           = PH_TRAILER;
          end else if (label_left == '0) begin
            if (label_tally != 7'h7f) begin
              label_tally_next = label_tally + 1'b1;
            end
            if (data_byte > 8'(MAX_LABEL_LEN)) begin
              label_code      = ST_LABEL_LONG;
              label_left_next = '0;
            end else begin
              label_left_next = data_byte[LABEL_W-1:0];
            end
          end else begin
            label_left_next = label_left - 1'b1;
          end
          if (first_error == ST_OK) begin
            first_error_next = label_code;
          end
        end
        PH_TRAILER: begin
          case (rel)
            OFFSET_BITS'(REL_QTYPE_HI):  qtype_next[15:8]  = qtype[15:8] | data_byte;
            OFFSET_BITS'(REL_QTYPE_LO):  qtype_next[7:0]   = qtype[7:0] | data_byte;
            OFFSET_BITS'(REL_QCLASS_HI): qclass_next[15:8] = qclass[15:8] | data_byte;
            OFFSET_BITS'(REL_QCLASS_LO): qclass_next[7:0]  = qclass[7:0] | data_byte;
            OFFSET_BITS'(REL_OWNER):     opt_owner_nz_next = opt_owner_nz | (data_byte != 8'h00);
            OFFSET_BITS'(REL_OTYPE_HI):  opt_type_next[15:8] = opt_type[15:8] | data_byte;
            OFFSET_BITS'(REL_OTYPE_LO):  opt_type_next[7:0]  = opt_type[7:0] | data_byte;
            OFFSET_BITS'(REL_OCLASS_HI): opt_class_next[15:8] = opt_class[15:8] | data_byte;
            OFFSET_BITS'(REL_OCLASS_LO): opt_class_next[7:0]  = opt_class[7:0] | data_byte;
            OFFSET_BITS'(REL_VERSION):   opt_version_next = opt_version | data_byte;
            OFFSET_BITS'(REL_DO):        opt_do_next      = opt_do | data_byte[7];
            default: ;
          endcase
        end
        default: ;
      endcase
    end
  end

  always_comb begin
    off_ext = {1'b0, byte_offset};
    end_p4  = {1'b0, name_end_offset_next} + (OFFSET_BITS + 1)'(MIN_TRAILER);
    end_p15 = {1'b0, name_end_offset_next} + (OFFSET_BITS + 1)'(MIN_OPT);
    opt_ok  = additional_flag_next && (off_ext >= end_p15) && !opt_owner_nz_next &&
              (opt_type_next == OPT_TYPE);

    summary           = '0;
    summary.item_kind = KIND_SUMMARY;
    if (!terminator_seen_next) begin
      summary.status = ST_UNTERMINATED;
    end else if (first_error_next != ST_OK) begin
      summary.status = first_error_next;
    end else if (name_end_offset_next > OFFSET_BITS'(MAX_NAME_END)) begin
      summary.status = ST_NAME_LONG;
    end else if (off_ext < end_p4) begin
      summary.status = ST_TRUNCATED;
    end else begin
      summary.status = ST_OK;
    end

    if (summary.status == ST_OK) begin
      summary.query_type       = qtype_next;
      summary.query_class      = qclass_next;
      summary.label_total      = label_tally_next;
      summary.name_wire_length =
        8'(name_end_offset_next - OFFSET_BITS'(HEADER_BYTES - 1));
      summary.recursion_wanted = rd_next;
      if (opt_ok) begin
        summary.edns_version  = opt_version_next;
        summary.edns_udp_size = (opt_class_next < UDP_FLOOR) ? UDP_FLOOR : opt_class_next;
        summary.edns_do       = opt_do_next;
      end
    end

    name_item           = '0;
    name_item.item_kind = KIND_NAME;
    name_item.name_byte = to_lower(data_byte);

    item_b     = summary;
    item_a     = (phase == PH_NAME) ? name_item : summary;
    push.count = fire ? (2'(phase == PH_NAME) + 2'(last_byte)) : 2'd0;
  end

  always_ff @(posedge clk) begin
    if (rst || (fire && last_byte)) begin
      phase           <= PH_HEADER;
      byte_offset     <= '0;
      label_left      <= '0;
      first_error     <= ST_OK;
      terminator_seen <= 1'b0;
      name_end_offset <= '0;
      label_tally     <= '0;
      qtype           <= '0;
      qclass          <= '0;
      rd              <= 1'b0;
      opt_type        <= '0;
      opt_class       <= '0;
      opt_version     <= '0;
      opt_do          <= 1'b0;
      opt_owner_nz    <= 1'b0;
      additional_flag <= 1'b0;
    end else begin
      phase           <= phase_next;
      byte_offset     <= byte_offset_next;
      label_left      <= label_left_next;
      first_error     <= first_error_next;
      terminator_seen <= terminator_seen_next;
      name_end_offset <= name_end_offset_next;
      label_tally     <= label_tally_next;
      qtype           <= qtype_next;
      qclass          <= qclass_next;
      rd              <= rd_next;
      opt_type        <= opt_type_next;
      opt_class       <= opt_class_next;
      opt_version     <= opt_version_next;
      opt_do          <= opt_do_next;
      opt_owner_nz    <= opt_owner_nz_next;
      additional_flag <= additional_flag_next;
    end
  end

endmodule

### rtl/core/dqp_result_fifo.sv
// Result word queue: takes up to two words a cycle, hands out one.
`timescale 1ns / 1ps
module dqp_result_fifo (
  input  logic                        clk,
  input  logic                        rst,
  input  dqp_pkg::push_t              push,
  input  dqp_pkg::result_t            item_a,
  input  dqp_pkg::result_t            item_b,
  output logic [dqp_pkg::RES_FILL_W-1:0] fill,
  dqp_out_if.source                   res_out
);
  import dqp_pkg::*;

  result_t              slots [RES_DEPTH];
  logic [RES_PTR_W-1:0] wr_ptr, rd_ptr;
  logic [RES_PTR_W-1:0] wr_ptr_b;
  logic                 pop;
  result_t              head;

  assign pop      = res_out.valid && res_out.ready;
  assign wr_ptr_b = wr_ptr + 1'b1;
  assign head     = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push.count != 2'd0) begin
      slots[wr_ptr] <= item_a;
    end
    if (push.count == 2'd2) begin
      slots[wr_ptr_b] <= item_b;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      wr_ptr <= wr_ptr + RES_PTR_W'(push.count);
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      fill <= fill + RES_FILL_W'(push.count) - RES_FILL_W'(pop);
    end
  end

  assign res_out.valid            = (fill != '0);
  assign res_out.item_kind        = head.item_kind;
  assign res_out.name_byte        = head.name_byte;
  assign res_out.status           = head.status;
  assign res_out.query_type       = head.query_type;
  assign res_out.query_class      = head.query_class;
  assign res_out.label_total      = head.label_total;
  assign res_out.name_wire_length = head.name_wire_length;
  assign res_out.recursion_wanted = head.recursion_wanted;
  assign res_out.edns_version     = head.edns_version;
  assign res_out.edns_udp_size    = head.edns_udp_size;
  assign res_out.edns_do          = head.edns_do;

endmodule

### rtl/core/dns_question_parser.sv
// Top level of the DNS question parser.
// Result words for an accepted byte are written into the result queue at the edge that accepts it.
// Throughput: one packet byte per cycle; each name byte gives one result word,
// and the final byte adds a summary word. A four-entry result queue takes up to
// two words a cycle and drains one, so input stalls only while the queue is backed up.
// Reset: synchronous rst empties the queue and returns the parser to the header phase.
`timescale 1ns / 1ps
`include "dns_question_parser_macros.svh"
module dns_question_parser #(
  parameter int OFFSET_BITS = 16
) (
  input logic       clk,
  input logic       rst,
  dqp_in_if.sink    pkt_in,
  dqp_out_if.source res_out
);
  import dqp_pkg::*;

  push_t                 push;
  result_t               item_a, item_b;
  logic [RES_FILL_W-1:0] fill;
  logic                  fire;

  assign pkt_in.ready = (fill <= RES_FILL_W'(RES_DEPTH - 2));
  assign fire         = pkt_in.valid && pkt_in.ready;

  dqp_parse #(
    .OFFSET_BITS(OFFSET_BITS)
  ) u_parse (
    .clk           (clk),
    .rst           (rst),
    .fire          (fire),
    .data_byte     (pkt_in.data_byte),
    .last_byte     (pkt_in.last_byte),
    .has_additional(pkt_in.has_additional),
    .push          (push),
    .item_a        (item_a),
    .item_b        (item_b)
  );

  dqp_result_fifo u_fifo (
    .clk    (clk),
    .rst    (rst),
    .push   (push),
    .item_a (item_a),
    .item_b (item_b),
    .fill   (fill),
    .res_out(res_out)
  );

  `DQP_ASSERT_SAME(a_fill_bound, 1'b1, fill <= RES_FILL_W'(RES_DEPTH), "result queue overflow")
  `DQP_ASSERT_NEXT(a_last_gives_word, fire && pkt_in.last_byte, fill != '0, "no summary queued")
  `DQP_ASSERT_SAME(a_name_ok, res_out.valid && res_out.item_kind == KIND_NAME, res_out.status == ST_OK && res_out.query_type == 16'd0, "name word carries summary data")
  `DQP_ASSERT_SAME(a_err_clear, res_out.valid && res_out.item_kind == KIND_SUMMARY && res_out.status != ST_OK, res_out.edns_udp_size == 16'd0 && res_out.name_wire_length == 8'd0, "error summary carries fields")

endmodule

### dv/tb_dns_question_parser.sv
`timescale 1ns / 1ps
// Testbench for the DNS question parser: packet bytes in, name and summary words checked.
module tb_dns_question_parser;
  import dqp_pkg::*;

  typedef enum logic [1:0] {PH_HEADER, PH_NAME, PH_TRAILER} parse_phase_e;

  typedef enum int {
    PKT_PLAIN, PKT_EDNS, PKT_LABEL_LONG, PKT_POINTER, PKT_ZERO_INSIDE, PKT_ZERO_LAST,
    PKT_NAME_LONG, PKT_TRUNCATED, PKT_UNTERMINATED, PKT_SHORT, PKT_NOISE
  } pkt_shape_e;

  localparam int IDLE_LIMIT     = 5000;
  localparam int DRAIN_CYCLES   = 16;
  localparam int OPT_RR_BYTES   = 11;
  localparam int OFFSET_BITS    = 9;
  localparam logic [15:0] OFFSET_LIMIT = 16'((1 << OFFSET_BITS) - 1);
  localparam logic [7:0] LABEL_POINTER = 8'hc0;
  localparam logic [7:0] EDGE_CHARS [8] = '{8'h01, 8'h40, 8'h41, 8'h5a, 8'h5b, 8'h60, 8'h7b,
                                           8'hff};

  logic clk;
  logic rst;

  dqp_in_if  pkt_in ();
  dqp_out_if res_out ();

  dns_question_parser #(
    .OFFSET_BITS(OFFSET_BITS)
  ) u_dut (
    .clk    (clk),
    .rst    (rst),
    .pkt_in (pkt_in),
    .res_out(res_out)
  );

  result_t     expected_words[$];
  logic [7:0]  pkt_bytes[$];
  logic        pkt_addl;
  int          mismatch_count = 0;
  int          idle_cycles = 0;
  int          send_idle_pct = 0;
  int          recv_idle_pct = 0;
  int          stall_left = 0;
  int unsigned bytes_sent = 0;

  parse_phase_e phase_now;
  logic [15:0]  pos_now;
  int unsigned  label_due;
  logic [2:0]   label_err;
  logic         name_closed;
  logic [15:0]  name_end;
  logic [6:0]   label_seen;
  logic [15:0]  qtype_acc;
  logic [15:0]  qclass_acc;
  logic [15:0]  opt_type_acc;
  logic [15:0]  opt_class_acc;
  logic [7:0]   opt_ver_acc;
  logic         rd_acc;
  logic         do_acc;
  logic         owner_nz;
  logic         addl_acc;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  function automatic void clear_parse_state();
    phase_now     = PH_HEADER;
    pos_now       = '0;
    label_due     = 0;
    label_err     = ST_OK;
    name_closed   = 1'b0;
    name_end      = '0;
    label_seen    = '0;
    qtype_acc     = '0;
    qclass_acc    = '0;
    opt_type_acc  = '0;
    opt_class_acc = '0;
    opt_ver_acc   = '0;
    rd_acc        = 1'b0;
    do_acc        = 1'b0;
    owner_nz      = 1'b0;
    addl_acc      = 1'b0;
  endfunction

  function automatic void note_label_error(logic [2:0] code);
    if (label_err == ST_OK) label_err = code;
  endfunction

  function automatic result_t packet_summary(int unsigned off);
    result_t     w;
    int unsigned end_i;
    logic [2:0]  st;
    w = '0;
    end_i = name_end;
    w.item_kind = KIND_SUMMARY;
    if (!name_closed) st = ST_UNTERMINATED;
    else if (label_err != ST_OK) st = label_err;
    else if (end_i > MAX_NAME_END) st = ST_NAME_LONG;
    else if (off < end_i + 4) st = ST_TRUNCATED;
    else st = ST_OK;
    w.status = st;
    if (st == ST_OK) begin
      w.query_type       = qtype_acc;
      w.query_class      = qclass_acc;
      w.label_total      = label_seen;
      w.name_wire_length = 8'(end_i - HEADER_BYTES + 1);
      w.recursion_wanted = rd_acc;
      if (addl_acc && off >= end_i + 15 && !owner_nz && opt_type_acc == OPT_TYPE) begin
        w.edns_version  = opt_ver_acc;
        w.edns_udp_size = (opt_class_acc < UDP_FLOOR) ? UDP_FLOOR : opt_class_acc;
        w.edns_do       = do_acc;
      end
    end
    return w;
  endfunction

  function automatic void parse_dns_byte(logic [7:0] b, logic last, logic addl);
    int unsigned off;
    int unsigned rel;
    result_t     w;
    off = pos_now;
    case (phase_now)
      PH_HEADER: begin
        if (off == 0) addl_acc = addl;
        if (off == HDR_FLAGS_OFFSET) rd_acc = b[0];
        if (off + 1 >= HEADER_BYTES) phase_now = PH_NAME;
      end
      PH_NAME: begin
        w = '0;
        w.item_kind = KIND_NAME;
        w.name_byte = (b >= 8'h41 && b <= 8'h5a) ? (b | 8'h20) : b;
        expected_words.push_back(w);
        if (b == 8'h00) begin
          if (label_due > 1) note_label_error(ST_LABEL_BEYOND);
          else if (label_due == 1) note_label_error(ST_MALFORMED);
          label_due   = 0;
          name_closed = 1'b1;
          name_end    = pos_now;
          phase_now   = PH_TRAILER;
        end else if (label_due == 0) begin
          if (label_seen != 7'h7f) label_seen++;
          if (b > MAX_LABEL_LEN) begin
            note_label_error(ST_LABEL_LONG);
            label_due = 0;
          end else begin
            label_due = b;
          end
        end else begin
          label_due--;
        end
      end
      default: begin
        rel = off - name_end;
        case (rel)
          1:  qtype_acc[15:8]     |= b;
          2:  qtype_acc[7:0]      |= b;
          3:  qclass_acc[15:8]    |= b;
          4:  qclass_acc[7:0]     |= b;
          5:  if (b != 8'h00) owner_nz = 1'b1;
          6:  opt_type_acc[15:8]  |= b;
          7:  opt_type_acc[7:0]   |= b;
          8:  opt_class_acc[15:8] |= b;
          9:  opt_class_acc[7:0]  |= b;
          11: opt_ver_acc         |= b;
          12: do_acc              |= b[7];
          default: ;
        endcase
      end
    endcase
    if (pos_now != OFFSET_LIMIT) pos_now++;
    if (last) begin
      expected_words.push_back(packet_summary(off));
      clear_parse_state();
    end
  endfunction

  function automatic void report_field(string fname, int unsigned exp_v, int unsigned got_v);
    if (exp_v != got_v) begin
      mismatch_count++;
      $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, fname, exp_v, got_v);
    end
  endfunction

  always @(posedge clk) begin
    result_t got;
    result_t want;
    if ((pkt_in.valid && pkt_in.ready) || (res_out.valid && res_out.ready)) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("%0t: no word moved for %0d cycles", $time, IDLE_LIMIT);
      $display("RESULT: ERROR");
      $finish;
    end
    if (!rst && res_out.valid && res_out.ready) begin
      got.item_kind        = res_out.item_kind;
      got.name_byte        = res_out.name_byte;
      got.status           = res_out.status;
      got.query_type       = res_out.query_type;
      got.query_class      = res_out.query_class;
      got.label_total      = res_out.label_total;
      got.name_wire_length = res_out.name_wire_length;
      got.recursion_wanted = res_out.recursion_wanted;
      got.edns_version     = res_out.edns_version;
      got.edns_udp_size    = res_out.edns_udp_size;
      got.edns_do          = res_out.edns_do;
      if (expected_words.size() == 0) begin
        mismatch_count++;
        $display("%0t: unexpected word, expected none, actual 0x%0h", $time, got);
      end else begin
        want = expected_words.pop_front();
        report_field("item_kind", want.item_kind, got.item_kind);
        report_field("name_byte", want.name_byte, got.name_byte);
        report_field("status", want.status, got.status);
        report_field("query_type", want.query_type, got.query_type);
        report_field("query_class", want.query_class, got.query_class);
        report_field("label_total", want.label_total, got.label_total);
        report_field("name_wire_length", want.name_wire_length, got.name_wire_length);
        report_field("recursion_wanted", want.recursion_wanted, got.recursion_wanted);
        report_field("edns_version", want.edns_version, got.edns_version);
        report_field("edns_udp_size", want.edns_udp_size, got.edns_udp_size);
        report_field("edns_do", want.edns_do, got.edns_do);
      end
    end
  end

  initial begin
    res_out.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (stall_left > 0) begin
        res_out.ready <= 1'b0;
        stall_left--;
      end else begin
        res_out.ready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  task automatic send_byte(logic [7:0] b, logic last, logic addl);
    while ($urandom_range(99) < send_idle_pct) begin
      pkt_in.valid <= 1'b0;
      @(negedge clk);
    end
    pkt_in.valid          <= 1'b1;
    pkt_in.data_byte      <= b;
    pkt_in.last_byte      <= last;
    pkt_in.has_additional <= addl;
    do @(posedge clk); while (!pkt_in.ready);
    parse_dns_byte(b, last, addl);
    bytes_sent++;
    @(negedge clk);
  endtask

  task automatic send_packet();
    for (int i = 0; i < pkt_bytes.size(); i++)
      send_byte(pkt_bytes[i], i == pkt_bytes.size() - 1,
                (i == 0) ? pkt_addl : 1'($urandom_range(1)));
  endtask

  function automatic logic [7:0] name_char();
    case ($urandom_range(4))
      0: return 8'h41 + 8'($urandom_range(25));
      1: return 8'h61 + 8'($urandom_range(25));
      2: return EDGE_CHARS[$urandom_range(7)];
      default: return 8'($urandom_range(1, 255));
    endcase
  endfunction

  function automatic void add_random(int count);
    repeat (count) pkt_bytes.push_back(8'($urandom_range(255)));
  endfunction

  function automatic void add_label(int len);
    pkt_bytes.push_back(8'(len));
    repeat (len) pkt_bytes.push_back(name_char());
  endfunction

  function automatic void add_name(int labels);
    repeat (labels)
      add_label(($urandom_range(9) == 0) ? $urandom_range(9, 63) : $urandom_range(1, 8));
    pkt_bytes.push_back(8'h00);
  endfunction

  function automatic void add_opt(logic [7:0] owner, logic [15:0] typ, logic [15:0] cls);
    pkt_bytes.push_back(owner);
    pkt_bytes.push_back(typ[15:8]);
    pkt_bytes.push_back(typ[7:0]);
    pkt_bytes.push_back(cls[15:8]);
    pkt_bytes.push_back(cls[7:0]);
    add_random(6);
  endfunction

  function automatic void build_packet(pkt_shape_e shape);
    int len;
    pkt_bytes.delete();
    pkt_addl = 1'($urandom_range(1));
    if (shape != PKT_SHORT && shape != PKT_NOISE) add_random(HEADER_BYTES);
    case (shape)
      PKT_PLAIN: begin
        add_name($urandom_range(1, 4));
        add_random(4);
        if ($urandom_range(3) == 0) add_random($urandom_range(1, 20));
      end
      PKT_EDNS: begin
        pkt_addl = ($urandom_range(9) != 0);
        add_name($urandom_range(1, 4));
        add_random(4);
        add_opt(($urandom_range(9) == 0) ? 8'($urandom_range(1, 255)) : 8'h00,
                ($urandom_range(9) == 0) ? 16'($urandom_range(65535)) : OPT_TYPE,
                $urandom_range(1) ? 16'($urandom_range(1023)) : 16'($urandom_range(65535)));
        if ($urandom_range(4) == 0) repeat ($urandom_range(1, OPT_RR_BYTES)) void'(pkt_bytes.pop_back());
        else if ($urandom_range(3) == 0) add_random($urandom_range(1, 10));
      end
      PKT_LABEL_LONG: begin
        if ($urandom_range(1)) add_label($urandom_range(1, 8));
        pkt_bytes.push_back(8'($urandom_range(64, 255)));
        add_name($urandom_range(0, 2));
        add_random(4);
      end
      PKT_POINTER: begin
        add_label($urandom_range(1, 8));
        pkt_bytes.push_back(LABEL_POINTER | 8'($urandom_range(63)));
        pkt_bytes.push_back(8'($urandom_range(HEADER_BYTES, 63)));
        pkt_bytes.push_back(8'h00);
        add_random(4);
      end
      PKT_ZERO_INSIDE: begin
        len = $urandom_range(2, 12);
        pkt_bytes.push_back(8'(len));
        repeat ($urandom_range(0, len - 2)) pkt_bytes.push_back(name_char());
        pkt_bytes.push_back(8'h00);
        add_random(4);
      end
      PKT_ZERO_LAST: begin
        len = $urandom_range(1, 12);
        pkt_bytes.push_back(8'(len));
        repeat (len - 1) pkt_bytes.push_back(name_char());
        pkt_bytes.push_back(8'h00);
        add_random(4);
      end
      PKT_NAME_LONG: begin
        repeat (3) add_label(MAX_LABEL_LEN);
        add_label($urandom_range(51, 63));
        pkt_bytes.push_back(8'h00);
        add_random(4);
      end
      PKT_TRUNCATED: begin
        add_name($urandom_range(1, 3));
        add_random($urandom_range(0, 3));
      end
      PKT_UNTERMINATED: begin
        repeat ($urandom_range(0, 30)) pkt_bytes.push_back(8'($urandom_range(1, 255)));
      end
      PKT_SHORT: add_random($urandom_range(1, HEADER_BYTES - 1));
      default: add_random($urandom_range(1, 60));
    endcase
  endfunction

  task automatic send_shape(pkt_shape_e shape);
    build_packet(shape);
    send_packet();
  endtask

  task automatic send_name_span(int tail_len);
    pkt_bytes.delete();
    pkt_addl = 1'b0;
    add_random(HEADER_BYTES);
    repeat (3) add_label(MAX_LABEL_LEN);
    add_label(tail_len);
    pkt_bytes.push_back(8'h00);
    add_random(4);
    send_packet();
  endtask

  task automatic send_edns_case(logic addl, logic [7:0] owner, logic [15:0] typ,
                                logic [15:0] cls, int drop);
    pkt_bytes.delete();
    pkt_addl = addl;
    add_random(HEADER_BYTES);
    add_name(2);
    add_random(4);
    add_opt(owner, typ, cls);
    repeat (drop) void'(pkt_bytes.pop_back());
    send_packet();
  endtask

  task automatic test_special_cases();
    pkt_bytes.delete();
    pkt_addl = 1'b1;
    add_random(1);
    send_packet();
    pkt_bytes.delete();
    add_random(HEADER_BYTES);
    send_packet();
    pkt_bytes.delete();
    add_random(HEADER_BYTES);
    pkt_bytes[HDR_FLAGS_OFFSET] = 8'hff;
    pkt_bytes.push_back(8'd8);
    foreach (EDGE_CHARS[i]) pkt_bytes.push_back(EDGE_CHARS[i]);
    add_label(MAX_LABEL_LEN);
    pkt_bytes.push_back(8'h00);
    pkt_bytes.push_back(8'hff);
    pkt_bytes.push_back(8'hff);
    pkt_bytes.push_back(8'h00);
    pkt_bytes.push_back(8'h00);
    send_packet();
    send_name_span(50);
    send_name_span(51);
    send_shape(PKT_LABEL_LONG);
    send_shape(PKT_POINTER);
    send_shape(PKT_ZERO_INSIDE);
    send_shape(PKT_ZERO_LAST);
    send_shape(PKT_UNTERMINATED);
    send_shape(PKT_TRUNCATED);
    send_edns_case(1'b1, 8'h00, OPT_TYPE, 16'h0000, 0);
    send_edns_case(1'b1, 8'h00, OPT_TYPE, UDP_FLOOR - 16'd1, 0);
    send_edns_case(1'b1, 8'h00, OPT_TYPE, 16'hffff, 0);
    send_edns_case(1'b1, 8'h01, OPT_TYPE, 16'h1000, 0);
    send_edns_case(1'b1, 8'h00, OPT_TYPE + 16'd1, 16'h1000, 0);
    send_edns_case(1'b0, 8'h00, OPT_TYPE, 16'h1000, 0);
    send_edns_case(1'b1, 8'h00, OPT_TYPE, 16'h1000, 1);
  endtask

  task automatic test_random_traffic(int unsigned byte_goal);
    int unsigned start;
    int          pick;
    start = bytes_sent;
    while (bytes_sent - start < byte_goal) begin
      pick = $urandom_range(99);
      if (pick < 45) send_shape(PKT_PLAIN);
      else if (pick < 70) send_shape(PKT_EDNS);
      else if (pick < 72) send_shape(PKT_NAME_LONG);
      else send_shape(pkt_shape_e'($urandom_range(PKT_LABEL_LONG, PKT_NOISE)));
    end
  endtask

  task automatic test_result_backpressure();
    stall_left = 400;
    repeat (3) begin
      build_packet(PKT_PLAIN);
      send_packet();
    end
  endtask

  task automatic test_offset_saturation();
    pkt_bytes.delete();
    pkt_addl = 1'b1;
    add_random(HEADER_BYTES);
    add_name(2);
    add_random(4);
    add_opt(8'h00, OPT_TYPE, 16'h1000);
    add_random(int'(OFFSET_LIMIT) + 64);
    send_packet();
  endtask

  initial begin
    rst                   = 1'b1;
    pkt_in.valid          = 1'b0;
    pkt_in.data_byte      = 8'h00;
    pkt_in.last_byte      = 1'b0;
    pkt_in.has_additional = 1'b0;
    clear_parse_state();
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    send_idle_pct = 13;
    recv_idle_pct = 88;
    test_special_cases();
    test_random_traffic(150);

    send_idle_pct = 88;
    recv_idle_pct = 13;
    test_random_traffic(150);

    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_random_traffic(100);
    test_result_backpressure();
    test_offset_saturation();

    pkt_in.valid <= 1'b0;
    while (expected_words.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && expected_words.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
